>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with async reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/mmc_sniff_pkg.sv
// ----------------------------------------------------------------------------
// mmc_sniff_pkg
// Constants and stream field layout for the MMC/SD bus deframer.
// ----------------------------------------------------------------------------
package mmc_sniff_pkg;

	localparam int MAX_BLOCK_BYTES_DEF = 4096;

	localparam int BLK_W     = 13;
	localparam int OFF_W     = 12;
	localparam int FRAME_BITS = 48;
	localparam int CMD_CNT_W = 6;

	localparam logic [BLK_W-1:0] BLOCK_BYTES_RST = 13'h208;
	localparam logic             SKIP_RST        = 1'b1;

	localparam logic [3:0] NIB_START = 4'h0;
	localparam logic [3:0] NIB_IDLE  = 4'hF;
	localparam logic [3:0] NIB_BUSY  = 4'hE;

	// configuration register indexes
	localparam int          CFG_IDX_W    = 2;
	localparam logic [1:0]  REG_BLOCK_BYTES = 2'd0;
	localparam logic [1:0]  REG_SKIP        = 2'd1;

	// dat_error codes
	localparam logic [1:0] DERR_NONE = 2'd0;
	localparam logic [1:0] DERR_IDLE = 2'd1;
	localparam logic [1:0] DERR_STOP = 2'd2;
	localparam logic [1:0] DERR_RSVD = 2'd3;

	// stream widths
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 72;
	localparam int OUT_TUSER_W = 2;

	// output tuser bits
	localparam int TU_CMD_VALID  = 0;
	localparam int TU_DATA_VALID = 1;

	// output tdata field positions (lsb)
	localparam int TD_BYTE_LSB = 47;
	localparam int TD_OFF_LSB  = 55;
	localparam int TD_LOST     = 67;
	localparam int TD_ERR_LSB  = 68;

endpackage

>>> hw/rtl/mmc_bus_sniffer_deframer_top.sv
// ----------------------------------------------------------------------------
// mmc_bus_sniffer_deframer_top
// MMC/SD 4-bit bus sniffer: command frame and data block deframer.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one bus sample per request: tdata[3:0] DAT lines,
//   tdata[4] CMD line, tdata[5] capture overflow flag.
//   m_axis carries decoded events: a finished 48-bit command frame, a data
//   byte with its block offset, an end-of-block (tlast) with stop check,
//   the overflow copy and idle/stop nibble errors. Samples that produce
//   no event produce no request on m_axis.
//   cfg writes block_bytes (index 0) or skip_after_start (index 1); cfg_ready
//   is always high. Write only while the stream is quiet.
// Timing:
//   One sample accepted per cycle unless m_axis stalls; an event is registered
//   and shows on m_axis in the cycle after its sample is accepted. Everything
//   is decoded combinationally between state registers and output register.
// Reset:
//   Both deframers go idle, block_bytes = 520, skip_after_start = 1,
//   output register empty.
// Stall:
//   While m_axis holds an event that is not taken, s_axis_tready is low
//   and the output register keeps its contents.
// ----------------------------------------------------------------------------
module mmc_bus_sniffer_deframer_top #(
	parameter int MAX_BLOCK_BYTES = mmc_sniff_pkg::MAX_BLOCK_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [3:0] dat_nibble, [4] cmd_line, [5] capture_overflow, [7:6] zero
	input  logic [mmc_sniff_pkg::IN_TDATA_W-1:0]   s_axis_tdata,

	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// [0] transmission_bit, [6:1] command_index, [38:7] command_argument,
	// [45:39] command_crc, [46] command_end_bit, [54:47] data_byte,
	// [66:55] byte_offset, [67] lost_data, [69:68] dat_error, [71:70] zero
	output logic [mmc_sniff_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// [0] cmd_valid, [1] data_valid
	output logic [mmc_sniff_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
	// block_done
	output logic                                   m_axis_tlast,

	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [mmc_sniff_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mmc_sniff_pkg::BLK_W-1:0]        cfg_data
);

	localparam int CNT_W = $clog2(MAX_BLOCK_BYTES + 1);
	localparam int CMP_W = (CNT_W > mmc_sniff_pkg::BLK_W) ? CNT_W : mmc_sniff_pkg::BLK_W;
	localparam int CC_W  = mmc_sniff_pkg::CMD_CNT_W;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_SKIP = 3'd1;
	localparam logic [2:0] PH_HIGH = 3'd2;
	localparam logic [2:0] PH_LOW  = 3'd3;
	localparam logic [2:0] PH_STOP = 3'd4;

	// config
	logic [mmc_sniff_pkg::BLK_W-1:0] block_bytes_q;
	logic                            skip_q;

	// state
	logic             cmd_active_q;
	logic [47:0]      cmd_shift_q;
	logic [CC_W-1:0]  cmd_cnt_q;
	logic [2:0]       phase_q;
	logic [CNT_W-1:0] byte_cnt_q;
	logic [3:0]       high_nib_q;

	// output register
	logic        out_valid_q;
	logic        cmd_valid_q;
	logic        tbit_q;
	logic [5:0]  idx_q;
	logic [31:0] arg_q;
	logic [6:0]  crc_q;
	logic        endb_q;
	logic        data_valid_q;
	logic [7:0]  byte_q;
	logic [mmc_sniff_pkg::OFF_W-1:0] off_q;
	logic        done_q;
	logic        lost_q;
	logic [1:0]  err_q;

	// sample fields
	logic [3:0] dat;
	logic       cmd;
	logic       ovf;
	logic       accept;

	// next-state logic
	logic             cmd_take;
	logic [47:0]      shift_nx;
	logic [CC_W-1:0]  cnt_inc;
	logic             frame_end;
	logic [2:0]       phase_nx;
	logic [CNT_W-1:0] byte_cnt_nx;
	logic [CNT_W-1:0] byte_inc;
	logic [3:0]       high_nib_nx;
	logic             dv;
	logic             done;
	logic [1:0]       err;
	logic [CMP_W-1:0] eff_len;
	logic             res_any;

	assign dat    = s_axis_tdata[3:0];
	assign cmd    = s_axis_tdata[4];
	assign ovf    = s_axis_tdata[5];
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	// command deframer
	assign cmd_take  = cmd_active_q || !cmd;
	assign shift_nx  = {cmd_shift_q[46:0], cmd};
	assign cnt_inc   = cmd_cnt_q + CC_W'(1);
	assign frame_end = cmd_take && (cnt_inc >= CC_W'(mmc_sniff_pkg::FRAME_BITS));

	// effective block length: zero acts as one, clamp to MAX_BLOCK_BYTES
	always_comb begin
		if (block_bytes_q == '0) begin
			eff_len = CMP_W'(1);
		end else if (CMP_W'(block_bytes_q) > CMP_W'(MAX_BLOCK_BYTES)) begin
			eff_len = CMP_W'(MAX_BLOCK_BYTES);
		end else begin
			eff_len = CMP_W'(block_bytes_q);
		end
	end

	assign byte_inc = byte_cnt_q + CNT_W'(1);

	// data deframer
	always_comb begin
		phase_nx    = phase_q;
		byte_cnt_nx = byte_cnt_q;
		high_nib_nx = high_nib_q;
		dv          = 1'b0;
		done        = 1'b0;
		err         = mmc_sniff_pkg::DERR_NONE;
		case (phase_q)
			PH_IDLE: begin
				if (dat == mmc_sniff_pkg::NIB_START) begin
					byte_cnt_nx = '0;
					phase_nx    = skip_q ? PH_SKIP : PH_HIGH;
				end else if (dat != mmc_sniff_pkg::NIB_IDLE &&
						dat != mmc_sniff_pkg::NIB_BUSY) begin
					err = mmc_sniff_pkg::DERR_IDLE;
				end
			end
			PH_SKIP: begin
				byte_cnt_nx = '0;
				phase_nx    = PH_HIGH;
			end
			PH_HIGH: begin
				high_nib_nx = dat;
				phase_nx    = PH_LOW;
			end
			PH_LOW: begin
				dv          = 1'b1;
				byte_cnt_nx = byte_inc;
				phase_nx    = (CMP_W'(byte_inc) >= eff_len) ? PH_STOP : PH_HIGH;
			end
			default: begin
				// stop sample
				done     = 1'b1;
				phase_nx = PH_IDLE;
				if (dat != mmc_sniff_pkg::NIB_IDLE) begin
					err = mmc_sniff_pkg::DERR_STOP;
				end
			end
		endcase
	end

	assign res_any = frame_end || dv || done || ovf || (err != mmc_sniff_pkg::DERR_NONE);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q <= mmc_sniff_pkg::BLOCK_BYTES_RST;
			skip_q        <= mmc_sniff_pkg::SKIP_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				mmc_sniff_pkg::REG_BLOCK_BYTES: block_bytes_q <= cfg_data;
				mmc_sniff_pkg::REG_SKIP:        skip_q        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// deframer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_active_q <= 1'b0;
			cmd_shift_q  <= '0;
			cmd_cnt_q    <= '0;
			phase_q      <= PH_IDLE;
			byte_cnt_q   <= '0;
			high_nib_q   <= '0;
		end else if (accept) begin
			if (cmd_take) begin
				if (frame_end) begin
					cmd_active_q <= 1'b0;
					cmd_shift_q  <= '0;
					cmd_cnt_q    <= '0;
				end else begin
					cmd_active_q <= 1'b1;
					cmd_shift_q  <= shift_nx;
					cmd_cnt_q    <= cnt_inc;
				end
			end
			phase_q    <= phase_nx;
			byte_cnt_q <= byte_cnt_nx;
			high_nib_q <= high_nib_nx;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= res_any;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (accept && res_any) begin
			cmd_valid_q  <= frame_end;
			tbit_q       <= frame_end ? shift_nx[46] : 1'b0;
			idx_q        <= frame_end ? shift_nx[45:40] : 6'd0;
			arg_q        <= frame_end ? shift_nx[39:8] : 32'd0;
			crc_q        <= frame_end ? shift_nx[7:1] : 7'd0;
			endb_q       <= frame_end ? shift_nx[0] : 1'b0;
			data_valid_q <= dv;
			byte_q       <= dv ? {high_nib_q, dat} : 8'd0;
			off_q        <= dv ? mmc_sniff_pkg::OFF_W'(byte_cnt_q) : '0;
			done_q       <= done;
			lost_q       <= ovf;
			err_q        <= err;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, err_q, lost_q, off_q, byte_q, endb_q, crc_q, arg_q,
		idx_q, tbit_q};
	assign m_axis_tuser  = {data_valid_q, cmd_valid_q};
	assign m_axis_tlast  = done_q;

endmodule

>>> hw/rtl/mmc_sniff_checker.sv
// ----------------------------------------------------------------------------
// mmc_sniff_checker
// Port-level checks for the MMC/SD bus deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmc_sniff_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [mmc_sniff_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [mmc_sniff_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
	input logic m_axis_tlast
);

	logic       dvalid;
	logic [7:0] dbyte;
	logic [mmc_sniff_pkg::OFF_W-1:0] doff;
	logic       lost;
	logic [1:0] derr;
	logic       any_event;

	assign dvalid = m_axis_tuser[mmc_sniff_pkg::TU_DATA_VALID];
	assign dbyte  = m_axis_tdata[mmc_sniff_pkg::TD_BYTE_LSB +: 8];
	assign doff   = m_axis_tdata[mmc_sniff_pkg::TD_OFF_LSB +: mmc_sniff_pkg::OFF_W];
	assign lost   = m_axis_tdata[mmc_sniff_pkg::TD_LOST];
	assign derr   = m_axis_tdata[mmc_sniff_pkg::TD_ERR_LSB +: 2];
	assign any_event = (m_axis_tuser != '0) || m_axis_tlast || lost ||
		(derr != mmc_sniff_pkg::DERR_NONE);

	// stalled request holds
	`ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
	// empty output never blocks input
	`ASSERT_IMPLY(a_ready, clk, arst_n, !m_axis_tvalid, s_axis_tready)
	// every request carries some event
	`ASSERT_IMPLY(a_event, clk, arst_n, m_axis_tvalid, any_event)
	// stop sample never carries a byte
	`ASSERT_IMPLY(a_stop_nobyte, clk, arst_n, m_axis_tvalid && m_axis_tlast, !dvalid)
	// byte fields zero without a byte, reserved error code never used
	`ASSERT_IMPLY(a_byte_zero, clk, arst_n, m_axis_tvalid && !dvalid, dbyte == 8'd0 && doff == '0 && derr != mmc_sniff_pkg::DERR_RSVD)

endmodule

bind mmc_bus_sniffer_deframer_top mmc_sniff_checker u_mmc_sniff_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

>>> tb/mmc_deframer_checker.sv
// ----------------------------------------------------------------------------
// mmc_deframer_checker
// Watches the sample, event and config channels of the MMC/SD bus deframer,
// predicts the decoded event for every accepted sample and compares each
// event request on m_axis against the oldest prediction.
// ----------------------------------------------------------------------------
module mmc_deframer_checker #(
	parameter int MAX_BLOCK_BYTES = mmc_sniff_pkg::MAX_BLOCK_BYTES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,

	input  logic                                  s_axis_tvalid,
	input  logic                                  s_axis_tready,
	input  logic [mmc_sniff_pkg::IN_TDATA_W-1:0]  s_axis_tdata,

	input  logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	input  logic [mmc_sniff_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic [mmc_sniff_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
	input  logic                                  m_axis_tlast,

	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  logic [mmc_sniff_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mmc_sniff_pkg::BLK_W-1:0]       cfg_data,

	output int                                    fail_count,
	output int                                    pending
);

	typedef enum logic [2:0] {
		DP_IDLE,
		DP_SKIP,
		DP_HIGH,
		DP_LOW,
		DP_STOP
	} dat_phase_t;

	typedef struct {
		logic        cmd_valid;
		logic        tx_bit;
		logic [5:0]  index;
		logic [31:0] arg;
		logic [6:0]  crc;
		logic        end_bit;
		logic        data_valid;
		logic [7:0]  data;
		logic [11:0] offset;
		logic        block_done;
		logic        lost;
		logic [1:0]  err;
	} bus_event_t;

	bus_event_t bus_event_q[$];

	logic [mmc_sniff_pkg::BLK_W-1:0]     block_bytes;
	logic                                skip_after_start;
	logic                                cmd_active;
	logic [47:0]                         cmd_shift;
	logic [mmc_sniff_pkg::CMD_CNT_W-1:0] cmd_bits;
	dat_phase_t                          phase;
	logic [16:0]                         byte_count;
	logic [3:0]                          high_nib;

	function automatic int unsigned block_len(input logic [mmc_sniff_pkg::BLK_W-1:0] bb);
		if (bb == 0)
			return 1;
		if (bb > MAX_BLOCK_BYTES)
			return MAX_BLOCK_BYTES;
		return 32'(bb);
	endfunction

	task decode_sample(input logic [mmc_sniff_pkg::IN_TDATA_W-1:0] smp);
		bus_event_t ev;
		logic [3:0] nib;
		logic       cmd_bit;
		ev = '{default: '0};
		nib = smp[3:0];
		cmd_bit = smp[4];
		ev.lost = smp[5];

		if (cmd_active || !cmd_bit) begin
			cmd_active = 1'b1;
			cmd_shift = {cmd_shift[46:0], cmd_bit};
			cmd_bits = cmd_bits + mmc_sniff_pkg::CMD_CNT_W'(1);
			if (cmd_bits >= mmc_sniff_pkg::FRAME_BITS) begin
				ev.cmd_valid = 1'b1;
				ev.tx_bit = cmd_shift[46];
				ev.index = cmd_shift[45:40];
				ev.arg = cmd_shift[39:8];
				ev.crc = cmd_shift[7:1];
				ev.end_bit = cmd_shift[0];
				cmd_shift = '0;
				cmd_bits = '0;
				cmd_active = 1'b0;
			end
		end

		case (phase)
			DP_IDLE: begin
				if (nib == mmc_sniff_pkg::NIB_START) begin
					byte_count = '0;
					phase = skip_after_start ? DP_SKIP : DP_HIGH;
				end else if (nib != mmc_sniff_pkg::NIB_IDLE &&
						nib != mmc_sniff_pkg::NIB_BUSY) begin
					ev.err = mmc_sniff_pkg::DERR_IDLE;
				end
			end
			DP_SKIP: begin
				byte_count = '0;
				phase = DP_HIGH;
			end
			DP_HIGH: begin
				high_nib = nib;
				phase = DP_LOW;
			end
			DP_LOW: begin
				ev.data_valid = 1'b1;
				ev.data = {high_nib, nib};
				ev.offset = byte_count[11:0];
				byte_count = byte_count + 17'd1;
				phase = (byte_count >= block_len(block_bytes)) ? DP_STOP : DP_HIGH;
			end
			default: begin
				ev.block_done = 1'b1;
				if (nib != mmc_sniff_pkg::NIB_IDLE)
					ev.err = mmc_sniff_pkg::DERR_STOP;
				phase = DP_IDLE;
			end
		endcase

		if (ev.cmd_valid || ev.data_valid || ev.block_done || ev.lost ||
				ev.err != mmc_sniff_pkg::DERR_NONE)
			bus_event_q.push_back(ev);
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		bus_event_t want;
		if (!arst_n) begin
			bus_event_q.delete();
			block_bytes = mmc_sniff_pkg::BLOCK_BYTES_RST;
			skip_after_start = mmc_sniff_pkg::SKIP_RST;
			cmd_active = 1'b0;
			cmd_shift = '0;
			cmd_bits = '0;
			phase = DP_IDLE;
			byte_count = '0;
			high_nib = '0;
			fail_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (bus_event_q.size() == 0) begin
					$error("event request on m_axis with no prediction pending");
					fail_count++;
				end else begin
					want = bus_event_q.pop_front();
					check_field("cmd_valid", 64'(want.cmd_valid),
						64'(m_axis_tuser[mmc_sniff_pkg::TU_CMD_VALID]));
					check_field("transmission_bit", 64'(want.tx_bit),
						64'(m_axis_tdata[0]));
					check_field("command_index", 64'(want.index),
						64'(m_axis_tdata[6:1]));
					check_field("command_argument", 64'(want.arg),
						64'(m_axis_tdata[38:7]));
					check_field("command_crc", 64'(want.crc),
						64'(m_axis_tdata[45:39]));
					check_field("command_end_bit", 64'(want.end_bit),
						64'(m_axis_tdata[46]));
					check_field("data_valid", 64'(want.data_valid),
						64'(m_axis_tuser[mmc_sniff_pkg::TU_DATA_VALID]));
					check_field("data_byte", 64'(want.data),
						64'(m_axis_tdata[mmc_sniff_pkg::TD_BYTE_LSB +: 8]));
					check_field("byte_offset", 64'(want.offset),
						64'(m_axis_tdata[mmc_sniff_pkg::TD_OFF_LSB +:
							mmc_sniff_pkg::OFF_W]));
					check_field("block_done", 64'(want.block_done),
						64'(m_axis_tlast));
					check_field("lost_data", 64'(want.lost),
						64'(m_axis_tdata[mmc_sniff_pkg::TD_LOST]));
					check_field("dat_error", 64'(want.err),
						64'(m_axis_tdata[mmc_sniff_pkg::TD_ERR_LSB +: 2]));
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mmc_sniff_pkg::REG_BLOCK_BYTES: block_bytes = cfg_data;
					mmc_sniff_pkg::REG_SKIP:        skip_after_start = cfg_data[0];
					default:                        ;
				endcase
			end

			if (s_axis_tvalid && s_axis_tready)
				decode_sample(s_axis_tdata);
		end
		pending = bus_event_q.size();
	end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives bus samples into the MMC/SD deframer: directed idle, error, block
// and frame cases, one default-size block, then random phases of command
// frames and data blocks under changing block length and skip settings,
// with random idling on both streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;
	localparam int RANDOM_SAMPLES = 450;

	logic                                  clk = 1'b0;
	logic                                  arst_n = 1'b0;

	logic                                  s_axis_tvalid = 1'b0;
	logic                                  s_axis_tready;
	logic [mmc_sniff_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;

	logic                                  m_axis_tvalid;
	logic                                  m_axis_tready = 1'b0;
	logic [mmc_sniff_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic [mmc_sniff_pkg::OUT_TUSER_W-1:0] m_axis_tuser;
	logic                                  m_axis_tlast;

	logic                                  cfg_valid = 1'b0;
	logic                                  cfg_ready;
	logic [mmc_sniff_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [mmc_sniff_pkg::BLK_W-1:0]       cfg_data = '0;

	int fail_count;
	int pending;

	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int rx_hold = 0;
	int samples_sent = 0;
	int quiet_cycles = 0;

	logic [3:0]                           nib_q[$];
	logic                                 cmd_q[$];
	logic [mmc_sniff_pkg::IN_TDATA_W-1:0] sample_q[$];

	always #1 clk = ~clk;

	mmc_bus_sniffer_deframer_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	mmc_deframer_checker event_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// event receiver
	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				m_axis_tready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end
			gap = rx_idle_on ? $urandom_range(0, 14) : 0;
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	function automatic int unsigned block_len(input logic [mmc_sniff_pkg::BLK_W-1:0] bb);
		if (bb == 0)
			return 1;
		if (bb > mmc_sniff_pkg::MAX_BLOCK_BYTES_DEF)
			return mmc_sniff_pkg::MAX_BLOCK_BYTES_DEF;
		return 32'(bb);
	endfunction

	task automatic push_sample(input logic [mmc_sniff_pkg::IN_TDATA_W-1:0] smp);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= smp;
		do @(posedge clk); while (!s_axis_tready);
		samples_sent++;
	endtask

	task automatic play();
		while (sample_q.size() > 0)
			push_sample(sample_q.pop_front());
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		@(posedge clk);
		wait (pending == 0);
	endtask

	task automatic cfg_write(input logic [mmc_sniff_pkg::CFG_IDX_W-1:0] idx,
			input logic [mmc_sniff_pkg::BLK_W-1:0] val);
		drain();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_block(input int unsigned len, input bit skip, input bit clean_stop);
		nib_q.push_back(mmc_sniff_pkg::NIB_START);
		if (skip)
			nib_q.push_back(4'($urandom_range(0, 15)));
		repeat (2 * len) nib_q.push_back(4'($urandom_range(0, 15)));
		nib_q.push_back(clean_stop ? mmc_sniff_pkg::NIB_IDLE : 4'($urandom_range(0, 15)));
	endtask

	task automatic add_idle(input int n, input bit noisy);
		repeat (n) begin
			if (noisy)
				nib_q.push_back(4'($urandom_range(0, 15)));
			else
				nib_q.push_back(($urandom_range(0, 3) == 0) ?
					mmc_sniff_pkg::NIB_BUSY : mmc_sniff_pkg::NIB_IDLE);
		end
	endtask

	task automatic add_frame();
		logic [47:0] frame;
		logic        tx;
		logic [5:0]  idx;
		logic [31:0] arg;
		logic [6:0]  crc;
		logic        end_bit;
		tx = 1'($urandom_range(0, 1));
		idx = 6'($urandom_range(0, 63));
		arg = $urandom;
		crc = 7'($urandom_range(0, 127));
		end_bit = ($urandom_range(0, 7) != 0);
		frame = {1'b0, tx, idx, arg, crc, end_bit};
		for (int i = 47; i >= 0; i--)
			cmd_q.push_back(frame[i]);
		repeat ($urandom_range(0, 6)) cmd_q.push_back(1'b1);
	endtask

	task automatic fill_frames();
		while (cmd_q.size() + 48 < nib_q.size())
			add_frame();
	endtask

	// zip DAT and CMD lanes into samples, idle level where a lane runs out
	task automatic merge_lanes();
		logic [3:0] nib;
		logic       cmd_bit;
		logic       ovf;
		while (nib_q.size() > 0 || cmd_q.size() > 0) begin
			nib = (nib_q.size() > 0) ? nib_q.pop_front() : mmc_sniff_pkg::NIB_IDLE;
			cmd_bit = (cmd_q.size() > 0) ? cmd_q.pop_front() : 1'b1;
			ovf = ($urandom_range(0, 31) == 0);
			sample_q.push_back({2'b00, ovf, cmd_bit, nib});
		end
	endtask

	initial begin
		logic [3:0]                      bad_nibs[7];
		logic [mmc_sniff_pkg::BLK_W-1:0] bb;
		bit                              skip;
		int                              phase_no;
		int                              kind;
		int unsigned                     target;

		bad_nibs = '{4'h1, 4'h2, 4'h4, 4'h8, 4'h7, 4'hD, 4'hB};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero length acts as one byte, no skip sample
		cfg_write(mmc_sniff_pkg::REG_BLOCK_BYTES, 13'd0);
		cfg_write(mmc_sniff_pkg::REG_SKIP, 13'd0);
		sample_q.push_back({2'b00, 1'b1, 1'b1, mmc_sniff_pkg::NIB_IDLE});
		sample_q.push_back({2'b00, 1'b0, 1'b1, mmc_sniff_pkg::NIB_BUSY});
		foreach (bad_nibs[i])
			sample_q.push_back({2'b00, 1'b0, 1'b1, bad_nibs[i]});
		sample_q.push_back({2'b00, 1'b0, 1'b1, mmc_sniff_pkg::NIB_START});
		sample_q.push_back({2'b00, 1'b0, 1'b1, 4'hA});
		sample_q.push_back({2'b00, 1'b0, 1'b1, 4'h5});
		sample_q.push_back({2'b00, 1'b0, 1'b1, mmc_sniff_pkg::NIB_IDLE});
		sample_q.push_back({2'b00, 1'b0, 1'b1, mmc_sniff_pkg::NIB_START});
		sample_q.push_back({2'b00, 1'b0, 1'b1, 4'h3});
		sample_q.push_back({2'b00, 1'b0, 1'b1, 4'hC});
		sample_q.push_back({2'b00, 1'b0, 1'b1, 4'h3});
		// frame end lands on the same sample as a data byte
		add_frame();
		cmd_q = cmd_q[0:47];
		repeat (45) nib_q.push_back(mmc_sniff_pkg::NIB_IDLE);
		add_block(1, 1'b0, 1'b1);
		merge_lanes();
		play();

		cfg_write(mmc_sniff_pkg::REG_BLOCK_BYTES, 13'd2);
		cfg_write(mmc_sniff_pkg::REG_SKIP, 13'd1);
		add_block(2, 1'b1, 1'b1);
		add_block(2, 1'b1, 1'b0);
		merge_lanes();
		play();

		// default-size block, streams kept busy
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		bb = mmc_sniff_pkg::BLOCK_BYTES_RST;
		skip = 1'b1;
		cfg_write(mmc_sniff_pkg::REG_BLOCK_BYTES, bb);
		cfg_write(mmc_sniff_pkg::REG_SKIP, mmc_sniff_pkg::BLK_W'(skip));
		add_block(block_len(bb), skip, 1'b1);
		fill_frames();
		merge_lanes();
		play();

		target = samples_sent + RANDOM_SAMPLES;
		phase_no = 0;
		while (samples_sent < target) begin
			bb = mmc_sniff_pkg::BLK_W'(($urandom_range(0, 3) == 0) ?
				$urandom_range(17, 64) : $urandom_range(0, 16));
			cfg_write(mmc_sniff_pkg::REG_BLOCK_BYTES, bb);
			if ($urandom_range(0, 1)) begin
				skip = 1'($urandom_range(0, 1));
				cfg_write(mmc_sniff_pkg::REG_SKIP, mmc_sniff_pkg::BLK_W'(skip));
			end
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(2, 6)) begin
				kind = $urandom_range(0, 9);
				if (kind < 7)
					add_block(block_len(bb), skip, 1'b1);
				else if (kind == 7)
					add_block(block_len(bb), skip, 1'b0);
				else
					add_idle($urandom_range(1, 12), 1'b1);
				add_idle($urandom_range(0, 4), 1'b0);
			end
			fill_frames();
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 40)) cmd_q.push_back(1'($urandom_range(0, 1)));
			merge_lanes();
			if (phase_no == 0) begin
				// receiver holds off while samples keep coming
				tx_idle_on = 1'b0;
				rx_hold = HOLD_CYCLES;
			end
			play();
			if (phase_no == 0)
				drain();
			phase_no++;
		end

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/mmc_sniff_pkg.sv
hw/rtl/mmc_bus_sniffer_deframer_top.sv
hw/rtl/mmc_sniff_checker.sv
tb/mmc_deframer_checker.sv
tb/testbench.sv
